// ===== design/i2c_master_bit_engine_defines.svh =====
// assertion macros for the design checker module i2cm_checker
`ifndef I2C_MASTER_BIT_ENGINE_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define I2CM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/i2cm_pkg.sv =====
`default_nettype none
package i2cm_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

  localparam logic [2:0] FUNC_START = 3'd0;
  localparam logic [2:0] FUNC_STOP  = 3'd1;
  localparam logic [2:0] FUNC_SEND  = 3'd2;
  localparam logic [2:0] FUNC_WAIT  = 3'd3;
  localparam logic [2:0] FUNC_READ  = 3'd4;

  // phase markers
  localparam logic [4:0] SEND_LAST    = 5'd24;
  localparam logic [4:0] READ_ACK_PH  = 5'd16;
  localparam logic [4:0] READ_ACK_HI  = 5'd17;
  localparam logic [4:0] READ_LAST    = 5'd18;
  localparam logic [4:0] WAIT_POLL_PH = 5'd1;
  localparam logic [4:0] WAIT_END_PH  = 5'd2;
  localparam logic [4:0] STOP_LAST    = 5'd2;
  localparam logic [1:0] SUB_HIGH     = 2'd1;
  localparam logic [1:0] SUB_LAST     = 2'd2;

  typedef enum logic [5:0] {
    CMD_IDLE  = 6'b000001,
    CMD_START = 6'b000010,
    CMD_STOP  = 6'b000100,
    CMD_SEND  = 6'b001000,
    CMD_WAIT  = 6'b010000,
    CMD_READ  = 6'b100000
  } cmd_t;

  typedef struct packed {
    logic       cmd_ok;
    cmd_t       cmd;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  function automatic cmd_t decode_func(input logic [2:0] f);
    cmd_t c;
    case (f)
      FUNC_START: c = CMD_START;
      FUNC_STOP:  c = CMD_STOP;
      FUNC_SEND:  c = CMD_SEND;
      FUNC_WAIT:  c = CMD_WAIT;
      FUNC_READ:  c = CMD_READ;
      default:    c = CMD_IDLE;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== design/i2cm_front.sv =====
`default_nettype none
module i2cm_front #(
  parameter int DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cmd_valid,
  input  logic [2:0]        func,
  input  logic [7:0]        tx_byte,
  input  logic              send_ack,
  input  logic              sda_in,
  output logic              q_valid,
  input  logic              q_ready,
  output i2cm_pkg::item_t   q_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  i2cm_pkg::item_t  mem [DEPTH];
  i2cm_pkg::item_t  item_in;
  i2cm_pkg::cmd_t   dec;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  // classify the beat before it enters the queue
  always_comb begin
    dec = i2cm_pkg::decode_func(func);
    item_in.cmd_ok   = cmd_valid && (dec != i2cm_pkg::CMD_IDLE);
    item_in.cmd      = dec;
    item_in.tx_byte  = tx_byte;
    item_in.send_ack = send_ack;
    item_in.sda_in   = sda_in;
  end

  assign in_ready = (count != CNT_W'(DEPTH));
  assign q_valid  = (count != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/i2cm_back.sv =====
`default_nettype none
module i2cm_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [7:0]      cfg_data,
  input  logic            q_valid,
  output logic            q_ready,
  input  i2cm_pkg::item_t q_item,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            scl,
  output logic            sda_release,
  output logic            busy_res,
  output logic            done_res,
  output logic [7:0]      rx_byte,
  output logic            ack_fail
);

  i2cm_pkg::cmd_t state, state_next, cur;
  logic [4:0] phase, phase_next, p;
  logic [1:0] sub, sub_next, sb;
  logic [7:0] shift_byte, shift_byte_next, sh;
  logic [7:0] poll_count, poll_count_next, pc;
  logic       scl_level, scl_level_next;
  logic       sda_level, sda_level_next;
  logic       fail_flag, fail_flag_next, ff;
  logic       ack_choice, ack_choice_next, ac;
  logic [7:0] rx_last, rx_last_next;
  logic [7:0] ack_timeout;
  logic       tick_scl, tick_sda, tick_busy, tick_done, tick_fail;
  logic       hold_phase;
  logic       go;

  assign cfg_ready = 1'b1;
  assign go        = q_valid && (!out_valid || out_ready);
  assign q_ready   = go;

  always_comb begin
    cur = state;
    p   = phase;
    pc  = poll_count;
    sh  = shift_byte;
    sb  = sub;
    ff  = fail_flag;
    ac  = ack_choice;
    // a new command starts on the same tick it is offered
    if (state == i2cm_pkg::CMD_IDLE && q_item.cmd_ok) begin
      cur = q_item.cmd;
      p   = '0;
      pc  = '0;
      sb  = '0;
      ff  = 1'b0;
      sh  = (q_item.cmd == i2cm_pkg::CMD_SEND) ? q_item.tx_byte : 8'd0;
      ac  = q_item.send_ack;
    end

    tick_scl        = scl_level;
    tick_sda        = sda_level;
    tick_busy       = 1'b0;
    tick_done       = 1'b0;
    tick_fail       = 1'b0;
    hold_phase      = 1'b0;
    state_next      = cur;
    phase_next      = p;
    sub_next        = sb;
    shift_byte_next = sh;
    poll_count_next = pc;
    fail_flag_next  = ff;
    ack_choice_next = ac;
    rx_last_next    = rx_last;
    scl_level_next  = scl_level;
    sda_level_next  = sda_level;

    case (cur)
      i2cm_pkg::CMD_START: begin
        tick_scl  = 1'b1;
        tick_sda  = (p == '0);
        tick_done = (p != '0);
      end
      i2cm_pkg::CMD_STOP: begin
        tick_scl  = (p != '0);
        tick_sda  = (p >= i2cm_pkg::STOP_LAST);
        tick_done = (p >= i2cm_pkg::STOP_LAST);
      end
      i2cm_pkg::CMD_SEND: begin
        if (p == '0) begin
          tick_scl = 1'b0;
          tick_sda = sda_level;
        end else begin
          // three ticks per bit: low, high, low; shift after the third
          tick_sda = sh[7];
          tick_scl = (sb == i2cm_pkg::SUB_HIGH);
          if (sb == i2cm_pkg::SUB_LAST) begin
            sub_next        = '0;
            shift_byte_next = {sh[6:0], 1'b0};
          end else begin
            sub_next = sb + 2'd1;
          end
          tick_done = (p >= i2cm_pkg::SEND_LAST);
        end
      end
      i2cm_pkg::CMD_WAIT: begin
        if (p == '0) begin
          tick_scl = scl_level;
          tick_sda = 1'b1;
        end else if (p == i2cm_pkg::WAIT_POLL_PH) begin
          tick_scl   = 1'b1;
          tick_sda   = 1'b1;
          hold_phase = 1'b1;
          if (!q_item.sda_in) begin
            phase_next = i2cm_pkg::WAIT_END_PH;
          end else if (pc == ack_timeout) begin
            // timed out: fall into a stop sequence and flag it
            state_next     = i2cm_pkg::CMD_STOP;
            phase_next     = '0;
            fail_flag_next = 1'b1;
          end else begin
            poll_count_next = pc + 8'd1;
          end
        end else begin
          tick_scl  = 1'b0;
          tick_sda  = 1'b1;
          tick_done = 1'b1;
        end
      end
      i2cm_pkg::CMD_READ: begin
        if (p < i2cm_pkg::READ_ACK_PH) begin
          tick_sda = 1'b1;
          tick_scl = p[0];
          if (p[0]) begin
            shift_byte_next = {sh[6:0], q_item.sda_in};
          end
        end else begin
          tick_sda  = !ac;
          tick_scl  = (p == i2cm_pkg::READ_ACK_HI);
          tick_done = (p >= i2cm_pkg::READ_LAST);
          if (p >= i2cm_pkg::READ_LAST) begin
            rx_last_next = sh;
          end
        end
      end
      default: begin
      end
    endcase

    if (cur != i2cm_pkg::CMD_IDLE) begin
      tick_busy      = 1'b1;
      scl_level_next = tick_scl;
      sda_level_next = tick_sda;
      if (tick_done) begin
        if (cur == i2cm_pkg::CMD_START) begin
          scl_level_next = 1'b0;
        end
        tick_fail      = ff;
        fail_flag_next = 1'b0;
        state_next     = i2cm_pkg::CMD_IDLE;
        phase_next     = '0;
      end else if (!hold_phase) begin
        phase_next = p + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= i2cm_pkg::CMD_IDLE;
      phase       <= '0;
      sub         <= '0;
      shift_byte  <= '0;
      poll_count  <= '0;
      scl_level   <= 1'b0;
      sda_level   <= 1'b1;
      fail_flag   <= 1'b0;
      ack_choice  <= 1'b0;
      rx_last     <= '0;
      ack_timeout <= i2cm_pkg::ACK_TIMEOUT_RST;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ack_timeout <= cfg_data;
      end
      if (go) begin
        state      <= state_next;
        phase      <= phase_next;
        sub        <= sub_next;
        shift_byte <= shift_byte_next;
        poll_count <= poll_count_next;
        scl_level  <= scl_level_next;
        sda_level  <= sda_level_next;
        fail_flag  <= fail_flag_next;
        ack_choice <= ack_choice_next;
        rx_last    <= rx_last_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (go) begin
      scl         <= tick_scl;
      sda_release <= tick_sda;
      busy_res    <= tick_busy;
      done_res    <= tick_done;
      rx_byte     <= rx_last_next;
      ack_fail    <= tick_fail;
    end
  end

endmodule
`default_nettype wire

// ===== design/i2c_master_bit_engine.sv =====
// i2c master bit engine: one result beat for every input beat (one bus tick each)
// a result is held in the queue and then in the output register before it leaves
// throughput: one beat per cycle unless stalled; one phase per beat, none in an ack poll
// reset (rst, synchronous, active high): engine idle, scl level low, sda level released,
// queue empty, no result pending, ack_timeout back to 250
`default_nettype none
module i2c_master_bit_engine #(
  parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       cmd_valid,
  input  logic [2:0] func,
  input  logic [7:0] tx_byte,
  input  logic       send_ack,
  input  logic       sda_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       scl,
  output logic       sda_release,
  output logic       busy_res,
  output logic       done_res,
  output logic [7:0] rx_byte,
  output logic       ack_fail
);

  logic            q_valid;
  logic            q_ready;
  i2cm_pkg::item_t q_item;

  i2cm_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd_valid (cmd_valid),
    .func      (func),
    .tx_byte   (tx_byte),
    .send_ack  (send_ack),
    .sda_in    (sda_in),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  i2cm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_item      (q_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .scl         (scl),
    .sda_release (sda_release),
    .busy_res    (busy_res),
    .done_res    (done_res),
    .rx_byte     (rx_byte),
    .ack_fail    (ack_fail)
  );

endmodule
`default_nettype wire

// ===== design/i2cm_checker.sv =====
`default_nettype none
`include "i2c_master_bit_engine_defines.svh"
module i2cm_checker (
  input logic       clk,
  input logic       rst,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic [7:0] cfg_data,
  input logic       in_valid,
  input logic       in_ready,
  input logic       cmd_valid,
  input logic [2:0] func,
  input logic [7:0] tx_byte,
  input logic       send_ack,
  input logic       sda_in,
  input logic       out_valid,
  input logic       out_ready,
  input logic       scl,
  input logic       sda_release,
  input logic       busy_res,
  input logic       done_res,
  input logic [7:0] rx_byte,
  input logic       ack_fail
);

  // a finishing tick is always part of a command
  `I2CM_ASSERT_NOW(a_done_busy, out_valid && done_res, busy_res, "done without busy")

  // failure is only reported on a finishing tick
  `I2CM_ASSERT_NOW(a_fail_done, out_valid && ack_fail, done_res, "ack_fail without done")

  // an idle beat reports neither completion nor failure
  `I2CM_ASSERT_NOW(a_idle_quiet, out_valid && !busy_res, !done_res && !ack_fail,
                   "idle beat reports completion")

  // a stalled result beat holds
  `I2CM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(scl) && $stable(sda_release) && $stable(rx_byte),
                    "stalled result beat changed")

endmodule

bind i2c_master_bit_engine i2cm_checker u_chk (.*);
`default_nettype wire

// ===== bench/i2cm_checker.sv =====
`timescale 1ns / 1ps
module i2cm_scoreboard (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       cmd_valid,
  input  logic [2:0] func,
  input  logic [7:0] tx_byte,
  input  logic       send_ack,
  input  logic       sda_in,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       scl,
  input  logic       sda_release,
  input  logic       busy_res,
  input  logic       done_res,
  input  logic [7:0] rx_byte,
  input  logic       ack_fail,
  output int         mismatches,
  output int         pending,
  output int         beats_checked,
  output int         completions,
  output int         ack_timeouts
);

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       fail;
  } line_state_t;

  // shadow of the engine
  i2cm_pkg::cmd_t engine_cmd;
  logic [4:0] engine_phase;
  logic [7:0] shifter;
  logic [7:0] polls_seen;
  logic [7:0] ack_limit;
  logic [7:0] rx_held;
  logic       scl_now;
  logic       sda_now;
  logic       fail_armed;
  logic       end_with_ack;

  line_state_t line_states_due[$];
  line_state_t want;
  line_state_t got;

  function automatic line_state_t advance_bus_tick(input logic cv, input logic [2:0] f,
                                                    input logic [7:0] b, input logic a,
                                                    input logic s);
    line_state_t r;
    logic [4:0]  ph;
    logic [4:0]  k;
    logic [2:0]  bit_no;
    r = '0;
    r.scl = scl_now;
    r.sda = sda_now;
    if (engine_cmd == i2cm_pkg::CMD_IDLE && cv && f <= i2cm_pkg::FUNC_READ) begin
      case (f)
        i2cm_pkg::FUNC_START: engine_cmd = i2cm_pkg::CMD_START;
        i2cm_pkg::FUNC_STOP:  engine_cmd = i2cm_pkg::CMD_STOP;
        i2cm_pkg::FUNC_SEND:  engine_cmd = i2cm_pkg::CMD_SEND;
        i2cm_pkg::FUNC_WAIT:  engine_cmd = i2cm_pkg::CMD_WAIT;
        default:              engine_cmd = i2cm_pkg::CMD_READ;
      endcase
      engine_phase = '0;
      polls_seen = '0;
      fail_armed = 1'b0;
      shifter = (f == i2cm_pkg::FUNC_SEND) ? b : 8'h00;
      end_with_ack = a;
    end
    if (engine_cmd != i2cm_pkg::CMD_IDLE) begin
      r.busy = 1'b1;
      ph = engine_phase;
      case (engine_cmd)
        i2cm_pkg::CMD_START: begin
          r.scl = 1'b1;
          r.sda = (ph == 0);
          r.done = (ph >= 1);
        end
        i2cm_pkg::CMD_STOP: begin
          r.scl = (ph != 0);
          r.sda = (ph >= 2);
          r.done = (ph >= 2);
        end
        i2cm_pkg::CMD_SEND: begin
          if (ph == 0) begin
            r.scl = 1'b0;
            r.sda = sda_now;
          end else begin
            k = ph - 5'd1;
            bit_no = 3'(k / 5'd3);
            r.sda = shifter[7 - bit_no];
            r.scl = (k % 5'd3 == 5'd1);
            r.done = (ph >= 24);
          end
        end
        i2cm_pkg::CMD_WAIT: begin
          if (ph == 0) begin
            r.scl = scl_now;
            r.sda = 1'b1;
          end else if (ph == 1) begin
            r.scl = 1'b1;
            r.sda = 1'b1;
            if (!s) begin
              engine_phase = 5'd2;
            end else if (polls_seen == ack_limit) begin
              // out of patience: fall into a stop and report it
              engine_cmd = i2cm_pkg::CMD_STOP;
              engine_phase = '0;
              fail_armed = 1'b1;
            end else begin
              polls_seen = polls_seen + 8'd1;
            end
          end else begin
            r.scl = 1'b0;
            r.sda = 1'b1;
            r.done = 1'b1;
          end
        end
        default: begin
          if (ph < 16) begin
            r.sda = 1'b1;
            r.scl = ph[0];
            if (ph[0]) shifter = {shifter[6:0], s};
          end else begin
            r.sda = !end_with_ack;
            r.scl = (ph == 17);
            if (ph >= 18) begin
              r.done = 1'b1;
              rx_held = shifter;
            end
          end
        end
      endcase
      scl_now = r.scl;
      sda_now = r.sda;
      if (r.done) begin
        if (engine_cmd == i2cm_pkg::CMD_START) scl_now = 1'b0;
        r.fail = fail_armed;
        fail_armed = 1'b0;
        engine_cmd = i2cm_pkg::CMD_IDLE;
        engine_phase = '0;
      end else if (!(engine_cmd == i2cm_pkg::CMD_WAIT && ph == 1) &&
                   !(engine_cmd == i2cm_pkg::CMD_STOP && engine_phase == 0 && fail_armed &&
                     ph == 1)) begin
        engine_phase = engine_phase + 5'd1;
      end
    end
    r.rx = rx_held;
    return r;
  endfunction

  function automatic string show_beat(input line_state_t t);
    return $sformatf("scl %0b sda %0b busy %0b done %0b rx %02h fail %0b",
                     t.scl, t.sda, t.busy, t.done, t.rx, t.fail);
  endfunction

  initial begin
    mismatches = 0;
    pending = 0;
    beats_checked = 0;
    completions = 0;
    ack_timeouts = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      engine_cmd = i2cm_pkg::CMD_IDLE;
      engine_phase = '0;
      shifter = '0;
      polls_seen = '0;
      ack_limit = i2cm_pkg::ACK_TIMEOUT_RST;
      rx_held = '0;
      scl_now = 1'b0;
      sda_now = 1'b1;
      fail_armed = 1'b0;
      end_with_ack = 1'b0;
      line_states_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) ack_limit = cfg_data;
      if (in_valid && in_ready)
        line_states_due.push_back(advance_bus_tick(cmd_valid, func, tx_byte, send_ack, sda_in));
      if (out_valid && out_ready) begin
        got = '{scl, sda_release, busy_res, done_res, rx_byte, ack_fail};
        beats_checked++;
        if (done_res) completions++;
        if (done_res && ack_fail) ack_timeouts++;
        if (line_states_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d came with nothing outstanding: %s", beats_checked,
                     show_beat(got));
        end else begin
          want = line_states_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("beat %0d mismatch\n  expected %s\n  actual   %s", beats_checked,
                       show_beat(want), show_beat(got));
          end
        end
      end
    end
    pending = line_states_due.size();
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_TICKS = 100;
  localparam int HOLD_CYCLES = 80;
  localparam int SDA_RAND = 0;
  localparam int SDA_LOW  = 1;
  localparam int SDA_HIGH = 2;
  localparam logic [2:0] FUNC_BAD_LO = 3'd5;
  localparam logic [2:0] FUNC_BAD_HI = 3'd7;

  logic       clk;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic       cmd_valid;
  logic [2:0] func;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic       sda_in;
  logic       out_valid;
  logic       out_ready;
  logic       scl;
  logic       sda_release;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_fail;

  int mismatches;
  int pending;
  int beats_checked;
  int completions;
  int ack_timeouts;

  int         ticks_sent;
  int         settings_used;
  int         cycles;
  logic [7:0] limit_now;
  bit         calm;
  bit         sink_calm;
  bit         hold_sink;

  i2c_master_bit_engine dut (.*);
  i2cm_scoreboard chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("no finish after %0d cycles", cycles);
    $display("status: fail");
    $finish;
  end

  function automatic logic line_level(input int mode);
    case (mode)
      SDA_LOW:  return 1'b0;
      SDA_HIGH: return 1'b1;
      default:  return 1'($urandom_range(0, 1));
    endcase
  endfunction

  function automatic int cmd_ticks(input logic [2:0] f);
    case (f)
      i2cm_pkg::FUNC_START: return 2;
      i2cm_pkg::FUNC_STOP:  return 3;
      i2cm_pkg::FUNC_SEND:  return 25;
      default:              return 19;
    endcase
  endfunction

  task automatic push_tick(input logic cv, input logic [2:0] f, input logic [7:0] b,
                           input logic a, input logic s);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd_valid <= cv;
    func <= f;
    tx_byte <= b;
    send_ack <= a;
    sda_in <= s;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    ticks_sent++;
    if ($urandom_range(0, 63) == 0) calm = !calm;
  endtask

  // tick while a command runs; any command offered here must be dropped
  task automatic busy_tick(input int mode);
    logic cv;
    cv = ($urandom_range(0, 5) == 0);
    push_tick(cv, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)), line_level(mode));
  endtask

  task automatic gap_ticks();
    logic cv;
    repeat ($urandom_range(0, 2)) begin
      cv = 1'($urandom_range(0, 1));
      push_tick(cv, cv ? 3'($urandom_range(FUNC_BAD_LO, FUNC_BAD_HI)) : 3'($urandom_range(0, 7)),
                8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    end
  endtask

  task automatic issue(input logic [2:0] f, input logic [7:0] b, input logic a,
                       input int mode);
    push_tick(1'b1, f, b, a, line_level(mode));
    repeat (cmd_ticks(f) - 1) busy_tick(mode);
  endtask

  // highs above the current limit run into the timeout and its stop
  task automatic poll_ack(input int highs, output bit acked);
    acked = (highs <= limit_now);
    push_tick(1'b1, i2cm_pkg::FUNC_WAIT, 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    if (acked) begin
      repeat (highs) busy_tick(SDA_HIGH);
      busy_tick(SDA_LOW);
      busy_tick(SDA_RAND);
    end else begin
      repeat (limit_now + 1) busy_tick(SDA_HIGH);
      repeat (3) busy_tick(SDA_RAND);
    end
  endtask

  task automatic ack_wait(output bit acked);
    int highs;
    int cap;
    cap = (limit_now < 6) ? limit_now : 6;
    if ($urandom_range(0, (limit_now <= 16) ? 4 : 39) == 0) highs = limit_now + 1;
    else if (limit_now <= 12 && $urandom_range(0, 3) == 0) highs = limit_now;
    else highs = $urandom_range(0, cap);
    poll_ack(highs, acked);
  endtask

  task automatic bus_transfer();
    logic [7:0] addr;
    int         n;
    bit         ok;
    addr = 8'($urandom_range(0, 255));
    n = $urandom_range(1, 3);
    issue(i2cm_pkg::FUNC_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
          SDA_RAND);
    gap_ticks();
    issue(i2cm_pkg::FUNC_SEND, addr, 1'($urandom_range(0, 1)), SDA_RAND);
    gap_ticks();
    ack_wait(ok);
    for (int i = 0; i < n && ok; i++) begin
      gap_ticks();
      if (addr[0]) begin
        issue(i2cm_pkg::FUNC_READ, 8'($urandom_range(0, 255)), i != n - 1, SDA_RAND);
      end else begin
        issue(i2cm_pkg::FUNC_SEND, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              SDA_RAND);
        gap_ticks();
        ack_wait(ok);
      end
    end
    // a timed-out wait has already put a stop on the bus
    if (ok) begin
      gap_ticks();
      issue(i2cm_pkg::FUNC_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
            SDA_RAND);
    end
    gap_ticks();
  endtask

  task automatic random_cmds();
    logic [2:0] f;
    bit         acked;
    repeat ($urandom_range(1, 5)) begin
      f = 3'($urandom_range(0, 4));
      if (f == i2cm_pkg::FUNC_WAIT) ack_wait(acked);
      else issue(f, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), SDA_RAND);
      gap_ticks();
    end
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(5, 20))
      push_tick(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    // quiet ticks so whatever got started can run out
    repeat (30)
      push_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_limit(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    limit_now = v;
    settings_used++;
  endtask

  // result side
  initial begin
    int wait_n;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      wait_n = sink_calm ? 0 : $urandom_range(0, 8);
      if (hold_sink) begin
        wait_n = HOLD_CYCLES;
        hold_sink = 1'b0;
      end
      if (wait_n > 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
      if ($urandom_range(0, 63) == 0) sink_calm = !sink_calm;
    end
  end

  initial begin
    bit acked;
    int stop_at;
    int pick;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    cmd_valid = 1'b0;
    func = i2cm_pkg::FUNC_START;
    tx_byte = '0;
    send_ack = 1'b0;
    sda_in = 1'b1;
    limit_now = i2cm_pkg::ACK_TIMEOUT_RST;
    ticks_sent = 0;
    settings_used = 1;
    calm = 1'b0;
    sink_calm = 1'b0;
    hold_sink = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // unknown codes while idle, then a stop offered mid-start
    for (int f = FUNC_BAD_LO; f <= FUNC_BAD_HI; f++)
      push_tick(1'b1, 3'(f), 8'hA5, 1'b1, 1'b0);
    push_tick(1'b1, i2cm_pkg::FUNC_START, 8'h00, 1'b0, 1'b1);
    push_tick(1'b1, i2cm_pkg::FUNC_STOP, 8'h00, 1'b0, 1'b0);
    issue(i2cm_pkg::FUNC_SEND, 8'hFF, 1'b0, SDA_RAND);
    poll_ack(0, acked);
    issue(i2cm_pkg::FUNC_READ, 8'h00, 1'b1, SDA_HIGH);
    issue(i2cm_pkg::FUNC_STOP, 8'h00, 1'b0, SDA_RAND);
    drain();
    set_limit(8'd0);
    issue(i2cm_pkg::FUNC_START, 8'h00, 1'b0, SDA_RAND);
    issue(i2cm_pkg::FUNC_SEND, 8'h00, 1'b1, SDA_RAND);
    poll_ack(1, acked);
    issue(i2cm_pkg::FUNC_START, 8'hFF, 1'b1, SDA_RAND);
    poll_ack(0, acked);
    issue(i2cm_pkg::FUNC_READ, 8'hFF, 1'b0, SDA_LOW);
    issue(i2cm_pkg::FUNC_STOP, 8'h00, 1'b0, SDA_RAND);

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0:       set_limit(8'd255);
        1:       set_limit(8'd1);
        2:       set_limit(8'd5);
        3:       set_limit(8'($urandom_range(2, 20)));
        default: set_limit(8'($urandom_range(0, 255)));
      endcase
      if (ph == 0) begin
        poll_ack(255, acked);
        gap_ticks();
        poll_ack(256, acked);
      end
      if (ph == 2) hold_sink = 1'b1;
      stop_at = ticks_sent + PHASE_TICKS;
      while (ticks_sent < stop_at) begin
        pick = $urandom_range(0, 19);
        if (pick < 14) bus_transfer();
        else if (pick < 17) random_cmds();
        else noise_burst();
      end
    end

    drain();
    repeat (10) @(negedge clk);
    $display("%0d bus ticks under %0d ack timeout settings, %0d result beats compared",
             ticks_sent, settings_used, beats_checked);
    $display("%0d commands finished on the bus, %0d of them through an ack timeout",
             completions, ack_timeouts);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
